>>> hdl/sppt_pkg.sv
package sppt_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_VERTEX_X = 2'd0;
  localparam logic [1:0] REG_VERTEX_Y = 2'd1;
  localparam logic [1:0] REG_VERTEX_Z = 2'd2;

  // Outcome codes of a result.
  localparam logic [1:0] OUTCOME_POINT      = 2'd0;
  localparam logic [1:0] OUTCOME_OFF_STRIP  = 2'd1;
  localparam logic [1:0] OUTCOME_DEGENERATE = 2'd2;

  // One strip pair: both ends of the first and of the second strip.
  typedef struct packed {
    logic signed [31:0] first_top_x;
    logic signed [31:0] first_top_y;
    logic signed [31:0] first_top_z;
    logic signed [31:0] first_bottom_x;
    logic signed [31:0] first_bottom_y;
    logic signed [31:0] first_bottom_z;
    logic signed [31:0] second_top_x;
    logic signed [31:0] second_top_y;
    logic signed [31:0] second_top_z;
    logic signed [31:0] second_bottom_x;
    logic signed [31:0] second_bottom_y;
    logic signed [31:0] second_bottom_z;
  } req_t;

  // One space point with its outcome.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [1:0]         outcome;
  } rsp_t;

endpackage

>>> hdl/sppt_mul.sv
// Pipelined signed multiplier. The wide operand a is cut into CW-bit chunks,
// one chunk is multiplied by b in each stage and added into the running sum.
module sppt_mul #(
  parameter int WA = 68,
  parameter int WB = 34,
  parameter int CW = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NC = (WA + CW - 1) / CW;
  localparam int WP = WA + WB;
  localparam int TW = WA - (NC - 1) * CW;

  logic signed [WA-1:0] a_d   [NC];
  logic signed [WB-1:0] b_d   [NC];
  logic signed [WP-1:0] acc   [NC];

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic signed [WA-1:0]    a_in;
    logic signed [WB-1:0]    b_in;
    logic signed [WP-1:0]    acc_in;
    logic signed [CW:0]      ch;
    logic signed [CW+WB:0]   prod;
    logic signed [WP-1:0]    term;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = b;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_d[k-1];
      assign b_in   = b_d[k-1];
      assign acc_in = acc[k-1];
    end

    // The top chunk carries the sign, lower chunks are unsigned.
    if (k == NC - 1) begin : g_top
      assign ch = {{(CW + 1 - TW){a_in[WA-1]}}, a_in[WA-1:k*CW]};
    end else begin : g_low
      assign ch = {1'b0, a_in[k*CW +: CW]};
    end

    assign prod = ch * b_in;
    assign term = WP'(prod) <<< (k * CW);

    always_ff @(posedge clk) begin
      if (en) begin
        a_d[k] <= a_in;
        b_d[k] <= b_in;
        acc[k] <= acc_in + term;
      end
    end
  end

  assign p = acc[NC-1];

endmodule

>>> hdl/sppt_div.sv
// Pipelined restoring divider, one quotient bit per stage. The upper WD bits
// of num must be below den, so the quotient fits in QB bits.
module sppt_div #(
  parameter int WD = 105,
  parameter int QB = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WD+QB-1:0] num,
  input  logic [WD-1:0]    den,
  output logic [QB-1:0]    quo,
  output logic [WD-1:0]    rem,
  output logic [WD-1:0]    den_out
);

  logic [WD-1:0] rem_d [QB];
  logic [WD-1:0] den_d [QB];
  logic [QB-1:0] low_d [QB];
  logic [QB-1:0] quo_d [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [WD-1:0] rem_in;
    logic [WD-1:0] den_in;
    logic [QB-1:0] low_in;
    logic [QB-1:0] quo_in;
    logic [WD:0]   sh;
    logic [WD+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = num[WD+QB-1:QB];
      assign den_in = den;
      assign low_in = num[QB-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_d[k-1];
      assign den_in = den_d[k-1];
      assign low_in = low_d[k-1];
      assign quo_in = quo_d[k-1];
    end

    // Shift in the next dividend bit and try a subtraction.
    assign sh   = {rem_in, low_in[QB-1]};
    assign diff = {1'b0, sh} - {2'b00, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_d[k] <= den_in;
        low_d[k] <= {low_in[QB-2:0], 1'b0};
        if (!diff[WD+1]) begin
          rem_d[k] <= diff[WD-1:0];
          quo_d[k] <= {quo_in[QB-2:0], 1'b1};
        end else begin
          rem_d[k] <= sh[WD-1:0];
          quo_d[k] <= {quo_in[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign quo     = quo_d[QB-1];
  assign rem     = rem_d[QB-1];
  assign den_out = den_d[QB-1];

endmodule

>>> hdl/strip_pair_space_point_core.sv
// Strip pair space point core.
// Throughput: one request per cycle while no result is stalled; the 32-stage divider sets the depth.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and the vertex registers to zero.
module strip_pair_space_point_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sppt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sppt_pkg::rsp_t rsp,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int WD = 105;
  localparam int QB = 32;
  localparam int S_DIV = 12;
  localparam int S_END = S_DIV + QB;

  // Round the quotient to nearest, apply the sign and saturate.
  function automatic logic [31:0] round_sat(input logic [QB-1:0] q,
                                            input logic [WD-1:0] r,
                                            input logic [WD-1:0] d,
                                            input logic neg);
    logic [QB:0]   mag;
    logic [31:0]   res;
    mag = {1'b0, q} + {{QB{1'b0}}, ({r, 1'b0} >= {1'b0, d})};
    if (neg) begin
      if (mag >= 33'h080000000) res = 32'h80000000;
      else res = 32'(33'd0 - mag);
    end else begin
      if (mag > 33'h07FFFFFFF) res = 32'h7FFFFFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  logic                 en;
  logic signed [31:0]   vtx [3];
  logic signed [31:0]   a_in [3];
  logic signed [31:0]   b_in [3];
  logic signed [31:0]   c_in [3];
  logic signed [31:0]   d_in [3];
  logic [S_END:1]       vld;

  logic signed [31:0]   a_p [7:1][3];
  logic signed [31:0]   b_p [7:1][3];
  logic signed [32:0]   q_p [3:1][3];
  logic signed [33:0]   s_p [3:1][3];
  logic signed [32:0]   r1 [3];
  logic signed [33:0]   t1 [3];
  logic signed [66:0]   pwa [3];
  logic signed [66:0]   pwb [3];
  logic signed [67:0]   w3 [3];
  logic signed [101:0]  pn [3];
  logic signed [100:0]  pd [3];
  logic signed [103:0]  num6;
  logic signed [103:0]  den6;
  logic signed [104:0]  lo7;
  logic signed [104:0]  hi7;
  logic signed [104:0]  twod7;
  logic [103:0]         an7;
  logic [103:0]         ad7;
  logic                 dz7;
  logic [WD-1:0]        dabs_p [S_DIV:8];
  logic                 dz_p   [S_END:8];
  logic                 off_p  [S_END:8];
  logic                 dneg_p [11:8];
  logic signed [136:0]  plo [3];
  logic signed [136:0]  phi [3];
  logic signed [137:0]  x11 [3];
  logic [WD+QB-1:0]     ax12 [3];
  logic                 neg_p [S_END:S_DIV][3];
  logic [QB-1:0]        quo [3];
  logic [WD-1:0]        rem [3];
  logic [WD-1:0]        dq [3];
  logic [31:0]          pt [3];

  // The pipeline advances unless a finished result is held back.
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // Vertex registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx[0] <= '0;
      vtx[1] <= '0;
      vtx[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sppt_pkg::REG_VERTEX_X: vtx[0] <= cfg_data;
        sppt_pkg::REG_VERTEX_Y: vtx[1] <= cfg_data;
        sppt_pkg::REG_VERTEX_Z: vtx[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[S_END-1:1], req_valid};
      rsp_valid <= vld[S_END];
    end
  end

  assign a_in[0] = req.first_top_x;
  assign a_in[1] = req.first_top_y;
  assign a_in[2] = req.first_top_z;
  assign b_in[0] = req.first_bottom_x;
  assign b_in[1] = req.first_bottom_y;
  assign b_in[2] = req.first_bottom_z;
  assign c_in[0] = req.second_top_x;
  assign c_in[1] = req.second_top_y;
  assign c_in[2] = req.second_top_z;
  assign d_in[0] = req.second_bottom_x;
  assign d_in[1] = req.second_bottom_y;
  assign d_in[2] = req.second_bottom_z;

  // Stage 1: strip directions and offsets from the vertex.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_p[1][i] <= a_in[i];
        b_p[1][i] <= b_in[i];
        q_p[1][i] <= 33'(a_in[i]) - 33'(b_in[i]);
        s_p[1][i] <= 34'(a_in[i]) + 34'(b_in[i]) - (34'(vtx[i]) <<< 1);
        r1[i]     <= 33'(c_in[i]) - 33'(d_in[i]);
        t1[i]     <= 34'(c_in[i]) + 34'(d_in[i]) - (34'(vtx[i]) <<< 1);
      end
      for (int st = 2; st <= 7; st++) begin
        a_p[st] <= a_p[st-1];
        b_p[st] <= b_p[st-1];
      end
      for (int st = 2; st <= 3; st++) begin
        q_p[st] <= q_p[st-1];
        s_p[st] <= s_p[st-1];
      end
    end
  end

  // Stages 2 to 5: cross product r x t, then its dot products with s and q.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    sppt_mul #(.WA(34), .WB(33), .CW(34)) u_mul_wa (
      .clk(clk), .en(en), .a(t1[K]), .b(r1[J]), .p(pwa[i])
    );
    sppt_mul #(.WA(34), .WB(33), .CW(34)) u_mul_wb (
      .clk(clk), .en(en), .a(t1[J]), .b(r1[K]), .p(pwb[i])
    );

    always_ff @(posedge clk) begin
      if (en) w3[i] <= 68'(pwa[i]) - 68'(pwb[i]);
    end

    sppt_mul #(.WA(68), .WB(34), .CW(34)) u_mul_num (
      .clk(clk), .en(en), .a(w3[i]), .b(s_p[3][i]), .p(pn[i])
    );
    sppt_mul #(.WA(68), .WB(33), .CW(34)) u_mul_den (
      .clk(clk), .en(en), .a(w3[i]), .b(q_p[3][i]), .p(pd[i])
    );

    // Stages 8 to 11: weighted sum of both strip ends.
    sppt_mul #(.WA(105), .WB(32), .CW(35)) u_mul_lo (
      .clk(clk), .en(en), .a(lo7), .b(a_p[7][i]), .p(plo[i])
    );
    sppt_mul #(.WA(105), .WB(32), .CW(35)) u_mul_hi (
      .clk(clk), .en(en), .a(hi7), .b(b_p[7][i]), .p(phi[i])
    );

    // Stage 12: magnitude and sign of the dividend.
    always_ff @(posedge clk) begin
      if (en) begin
        x11[i] <= 138'(plo[i]) + 138'(phi[i]);
        if (x11[i][137]) ax12[i] <= (WD + QB)'(138'd0 - x11[i]);
        else ax12[i] <= (WD + QB)'(x11[i]);
        neg_p[S_DIV][i] <= x11[i][137] ^ dneg_p[11];
      end
    end

    sppt_div #(.WD(WD), .QB(QB)) u_div (
      .clk(clk), .en(en), .num(ax12[i]), .den(dabs_p[S_DIV]),
      .quo(quo[i]), .rem(rem[i]), .den_out(dq[i])
    );

    assign pt[i] = round_sat(quo[i], rem[i], dq[i], neg_p[S_END][i]);
  end

  // Stages 6 to 8: dot product sums, then the limits and the flags.
  always_ff @(posedge clk) begin
    if (en) begin
      num6  <= 104'(pn[0]) + 104'(pn[1]) + 104'(pn[2]);
      den6  <= 104'(pd[0]) + 104'(pd[1]) + 104'(pd[2]);
      lo7   <= 105'(den6) - 105'(num6);
      hi7   <= 105'(den6) + 105'(num6);
      twod7 <= 105'(den6) <<< 1;
      an7   <= num6[103] ? 104'(104'd0 - num6) : 104'(num6);
      ad7   <= den6[103] ? 104'(104'd0 - den6) : 104'(den6);
      dz7   <= (den6 == '0);
      off_p[8]  <= (an7 > ad7);
      dz_p[8]   <= dz7;
      dneg_p[8] <= twod7[104];
      dabs_p[8] <= twod7[104] ? WD'(105'd0 - twod7) : WD'(twod7);
      for (int st = 9; st <= S_END; st++) begin
        off_p[st] <= off_p[st-1];
        dz_p[st]  <= dz_p[st-1];
      end
      for (int st = 9; st <= 11; st++) dneg_p[st] <= dneg_p[st-1];
      for (int st = 9; st <= S_DIV; st++) dabs_p[st] <= dabs_p[st-1];
      for (int st = S_DIV + 1; st <= S_END; st++) neg_p[st] <= neg_p[st-1];
    end
  end

  // Output register: the point or a rejection with zeroed coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_p[S_END]) begin
        rsp.point_x <= '0;
        rsp.point_y <= '0;
        rsp.point_z <= '0;
        rsp.outcome <= sppt_pkg::OUTCOME_DEGENERATE;
      end else if (off_p[S_END]) begin
        rsp.point_x <= '0;
        rsp.point_y <= '0;
        rsp.point_z <= '0;
        rsp.outcome <= sppt_pkg::OUTCOME_OFF_STRIP;
      end else begin
        rsp.point_x <= pt[0];
        rsp.point_y <= pt[1];
        rsp.point_z <= pt[2];
        rsp.outcome <= sppt_pkg::OUTCOME_POINT;
      end
    end
  end

endmodule
